// ----- design/assert_macros.svh -----
// Concurrent assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BNPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BNPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bnpc_pkg.sv -----
package bnpc_pkg;

    localparam int EPS_W     = 15;
    localparam int MINPTS_W  = 6;
    localparam int LABEL_W   = 6;
    localparam int INDEX_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [LABEL_W-1:0]   t_label;

    localparam t_cfg_idx CFG_EPS_LONG   = 2'd0;
    localparam t_cfg_idx CFG_EPS_LAT    = 2'd1;
    localparam t_cfg_idx CFG_MIN_POINTS = 2'd2;

    localparam logic [EPS_W-1:0]    EPS_LONG_RST   = 15'd2500;
    localparam logic [EPS_W-1:0]    EPS_LAT_RST    = 15'd220;
    localparam logic [MINPTS_W-1:0] MIN_POINTS_RST = 6'd1;

    localparam t_label LABEL_NOISE = 6'h3F;

endpackage

// ----- design/box_neighbourhood_point_clustering_unit.sv -----
// Box-neighbourhood point clustering. Points are loaded one per start pulse
// (busy stays low) until a point marked final; then busy rises and the block
// clusters the n loaded points. The core test runs on the single neighbour
// comparator fed by the two read ports of the point memory, one point pair
// per cycle. Every core point is then popped from the expansion stack and
// compared against all n points, and an outer scan steps over every point.
// The n labels then leave on consecutive cycles, one per cycle marked by
// o_strobe, in load order; the receiver cannot stall them, so it must take
// one label every cycle. Busy falls the cycle after the label flagged end of
// set.
module box_neighbourhood_point_clustering_unit #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_BITS-1:0]         i_pos_long,
    input  logic signed [COORD_BITS-1:0]         i_pos_lat,
    input  logic                                 i_is_final,
    output logic                                 o_strobe,
    output logic [bnpc_pkg::INDEX_W-1:0]         o_point_index,
    output logic signed [bnpc_pkg::LABEL_W-1:0]  o_cluster_label,
    output logic                                 o_dropped_points,
    output logic                                 o_end_of_set,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bnpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bnpc_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int KW = (CW > bnpc_pkg::MINPTS_W) ? CW : bnpc_pkg::MINPTS_W;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_CORE     = 10'b00_0000_0010,
        S_CORE_END = 10'b00_0000_0100,
        S_SCAN     = 10'b00_0000_1000,
        S_POP      = 10'b00_0001_0000,
        S_POPW     = 10'b00_0010_0000,
        S_EXP      = 10'b00_0100_0000,
        S_EXP_END  = 10'b00_1000_0000,
        S_OUT      = 10'b01_0000_0000,
        S_OUT_END  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [bnpc_pkg::EPS_W-1:0]    r_eps_long;
    logic [bnpc_pkg::EPS_W-1:0]    r_eps_lat;
    logic [bnpc_pkg::MINPTS_W-1:0] r_min_points;

    logic [CW-1:0]            r_count, n_count;
    logic                     r_overflow, n_overflow;
    bnpc_pkg::t_label         r_cc, n_cc;
    logic [MAX_POINTS-1:0]    r_visited, n_visited;
    logic [MAX_POINTS-1:0]    r_core, n_core;
    logic [CW-1:0]            r_scan, n_scan;
    logic [CW-1:0]            r_sp, n_sp;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic                     r_pv, n_pv;
    logic                     r_ov, n_ov;

    logic [AW-1:0]            r_row, n_row;
    logic [AW-1:0]            r_col, n_col;
    logic [AW-1:0]            r_prow, n_prow;
    logic [AW-1:0]            r_pcol, n_pcol;
    logic                     r_plast, n_plast;
    logic [AW-1:0]            r_oidx, n_oidx;
    logic                     r_olast, n_olast;

    bnpc_pkg::t_label         r_label_mem [MAX_POINTS];
    bnpc_pkg::t_label         r_lbl_q;
    logic [AW-1:0]            r_stack_mem [MAX_POINTS];
    logic [AW-1:0]            r_stk_q;

    logic                     accept;
    logic                     near;
    logic                     pt_we;
    logic [AW-1:0]            last_idx;
    logic                     core_mode;
    logic                     exp_mode;
    logic [CW-1:0]            cnt_sum;
    logic                     core_hit;
    logic                     push_hit;
    logic                     lbl_we;
    logic [AW-1:0]            lbl_waddr;
    bnpc_pkg::t_label         lbl_wdata;
    logic                     stk_we;
    logic [AW-1:0]            stk_waddr;
    logic [AW-1:0]            stk_wdata;
    logic [AW-1:0]            stk_raddr;

    bnpc_point_store #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_point_store (
        .i_clk      (i_clk),
        .i_we       (pt_we),
        .i_waddr    (r_count[AW-1:0]),
        .i_wlong    (i_pos_long),
        .i_wlat     (i_pos_lat),
        .i_raddr_a  (r_row),
        .i_raddr_b  (r_col),
        .i_eps_long (r_eps_long),
        .i_eps_lat  (r_eps_lat),
        .o_near     (near)
    );

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps_long   <= bnpc_pkg::EPS_LONG_RST;
            r_eps_lat    <= bnpc_pkg::EPS_LAT_RST;
            r_min_points <= bnpc_pkg::MIN_POINTS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bnpc_pkg::CFG_EPS_LONG:   r_eps_long   <= i_cfg_data;
                bnpc_pkg::CFG_EPS_LAT:    r_eps_lat    <= i_cfg_data;
                bnpc_pkg::CFG_MIN_POINTS: r_min_points <= i_cfg_data[bnpc_pkg::MINPTS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        last_idx  = AW'(r_count - CW'(1));
        core_mode = (r_state == S_CORE) || (r_state == S_CORE_END);
        exp_mode  = (r_state == S_EXP) || (r_state == S_EXP_END);
        cnt_sum   = r_cnt + CW'(near);
        core_hit  = KW'(cnt_sum) >= KW'(r_min_points);
        push_hit  = r_pv && exp_mode && r_core[r_pcol] && !r_visited[r_pcol] && near;
        stk_raddr = AW'(r_sp - CW'(1));

        n_state    = r_state;
        n_count    = r_count;
        n_overflow = r_overflow;
        n_cc       = r_cc;
        n_visited  = r_visited;
        n_core     = r_core;
        n_scan     = r_scan;
        n_sp       = r_sp;
        n_cnt      = r_cnt;
        n_pv       = 1'b0;
        n_ov       = 1'b0;
        n_row      = r_row;
        n_col      = r_col;
        n_prow     = r_prow;
        n_pcol     = r_pcol;
        n_plast    = r_plast;
        n_oidx     = r_oidx;
        n_olast    = r_olast;
        pt_we      = 1'b0;
        lbl_we     = 1'b0;
        lbl_waddr  = r_pcol;
        lbl_wdata  = r_cc;
        stk_we     = 1'b0;
        stk_waddr  = r_sp[AW-1:0];
        stk_wdata  = r_pcol;

        // neighbour result of the pair read in the previous cycle
        if (r_pv && core_mode) begin
            if (r_plast) begin
                n_core[r_prow] = core_hit;
                n_cnt          = '0;
            end else begin
                n_cnt = cnt_sum;
            end
        end
        if (push_hit) begin
            n_visited[r_pcol] = 1'b1;
            lbl_we            = 1'b1;
            stk_we            = 1'b1;
            n_sp              = r_sp + CW'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_count < CW'(MAX_POINTS)) begin
                        pt_we   = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_is_final) begin
                        n_state = S_CORE;
                        n_row   = '0;
                        n_col   = '0;
                        n_cnt   = '0;
                    end
                end
            end
            S_CORE: begin
                n_pv    = 1'b1;
                n_prow  = r_row;
                n_pcol  = r_col;
                n_plast = (r_col == last_idx);
                if (r_col == last_idx) begin
                    n_col = '0;
                    if (r_row == last_idx) begin
                        n_state = S_CORE_END;
                    end else begin
                        n_row = r_row + AW'(1);
                    end
                end else begin
                    n_col = r_col + AW'(1);
                end
            end
            S_CORE_END: begin
                n_scan  = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_scan == r_count) begin
                    n_col   = '0;
                    n_state = S_OUT;
                end else if (r_visited[r_scan[AW-1:0]]) begin
                    n_scan = r_scan + CW'(1);
                end else if (r_core[r_scan[AW-1:0]]) begin
                    n_visited[r_scan[AW-1:0]] = 1'b1;
                    lbl_we    = 1'b1;
                    lbl_waddr = r_scan[AW-1:0];
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = r_scan[AW-1:0];
                    n_sp      = CW'(1);
                    n_state   = S_POP;
                end else begin
                    lbl_we    = 1'b1;
                    lbl_waddr = r_scan[AW-1:0];
                    lbl_wdata = bnpc_pkg::LABEL_NOISE;
                    n_cc      = r_cc + bnpc_pkg::LABEL_W'(1);
                    n_scan    = r_scan + CW'(1);
                end
            end
            S_POP: begin
                n_sp    = r_sp - CW'(1);
                n_state = S_POPW;
            end
            S_POPW: begin
                n_row   = r_stk_q;
                n_col   = '0;
                n_state = S_EXP;
            end
            S_EXP: begin
                n_pv    = 1'b1;
                n_prow  = r_row;
                n_pcol  = r_col;
                n_plast = (r_col == last_idx);
                if (r_col == last_idx) begin
                    n_state = S_EXP_END;
                end else begin
                    n_col = r_col + AW'(1);
                end
            end
            S_EXP_END: begin
                if (n_sp == '0) begin
                    n_cc    = r_cc + bnpc_pkg::LABEL_W'(1);
                    n_scan  = r_scan + CW'(1);
                    n_state = S_SCAN;
                end else begin
                    n_state = S_POP;
                end
            end
            S_OUT: begin
                n_ov    = 1'b1;
                n_oidx  = r_col;
                n_olast = (r_col == last_idx);
                if (r_col == last_idx) begin
                    n_state = S_OUT_END;
                end else begin
                    n_col = r_col + AW'(1);
                end
            end
            S_OUT_END: begin
                n_count    = '0;
                n_overflow = 1'b0;
                n_visited  = '0;
                n_cc       = '0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_cc       <= '0;
            r_visited  <= '0;
            r_scan     <= '0;
            r_sp       <= '0;
            r_cnt      <= '0;
            r_pv       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_cc       <= n_cc;
            r_visited  <= n_visited;
            r_scan     <= n_scan;
            r_sp       <= n_sp;
            r_cnt      <= n_cnt;
            r_pv       <= n_pv;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_core  <= n_core;
        r_row   <= n_row;
        r_col   <= n_col;
        r_prow  <= n_prow;
        r_pcol  <= n_pcol;
        r_plast <= n_plast;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (lbl_we) begin
            r_label_mem[lbl_waddr] <= lbl_wdata;
        end
        r_lbl_q <= r_label_mem[r_col];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_q <= r_stack_mem[stk_raddr];
    end

    assign o_strobe         = r_ov;
    assign o_point_index    = bnpc_pkg::INDEX_W'(r_oidx);
    assign o_cluster_label  = $signed(r_lbl_q);
    assign o_dropped_points = r_overflow;
    assign o_end_of_set     = r_olast;

endmodule

// ----- design/bnpc_point_store.sv -----
module bnpc_point_store #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [$clog2(MAX_POINTS)-1:0]        i_waddr,
    input  logic signed [COORD_BITS-1:0]         i_wlong,
    input  logic signed [COORD_BITS-1:0]         i_wlat,
    input  logic [$clog2(MAX_POINTS)-1:0]        i_raddr_a,
    input  logic [$clog2(MAX_POINTS)-1:0]        i_raddr_b,
    input  logic [bnpc_pkg::EPS_W-1:0]           i_eps_long,
    input  logic [bnpc_pkg::EPS_W-1:0]           i_eps_lat,
    output logic                                 o_near
);

    localparam int DW = (COORD_BITS + 1 > bnpc_pkg::EPS_W) ? COORD_BITS + 1 : bnpc_pkg::EPS_W;

    logic [2*COORD_BITS-1:0] r_mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0] r_qa;
    logic [2*COORD_BITS-1:0] r_qb;

    logic signed [COORD_BITS:0] a_long;
    logic signed [COORD_BITS:0] b_long;
    logic signed [COORD_BITS:0] a_lat;
    logic signed [COORD_BITS:0] b_lat;
    logic signed [COORD_BITS:0] d_long;
    logic signed [COORD_BITS:0] d_lat;
    logic [COORD_BITS:0]        m_long;
    logic [COORD_BITS:0]        m_lat;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wlong, i_wlat};
        end
        r_qa <= r_mem[i_raddr_a];
        r_qb <= r_mem[i_raddr_b];
    end

    always_comb begin
        a_long = {r_qa[2*COORD_BITS-1], r_qa[2*COORD_BITS-1:COORD_BITS]};
        b_long = {r_qb[2*COORD_BITS-1], r_qb[2*COORD_BITS-1:COORD_BITS]};
        a_lat  = {r_qa[COORD_BITS-1], r_qa[COORD_BITS-1:0]};
        b_lat  = {r_qb[COORD_BITS-1], r_qb[COORD_BITS-1:0]};
        d_long = a_long - b_long;
        d_lat  = a_lat - b_lat;
        m_long = d_long[COORD_BITS] ? $unsigned(-d_long) : $unsigned(d_long);
        m_lat  = d_lat[COORD_BITS] ? $unsigned(-d_lat) : $unsigned(d_lat);
        o_near = (DW'(m_long) < DW'(i_eps_long)) && (DW'(m_lat) < DW'(i_eps_lat));
    end

endmodule

// ----- design/bnpc_checker.sv -----
`include "assert_macros.svh"

module bnpc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_is_final,
    input logic                          o_strobe,
    input logic [bnpc_pkg::INDEX_W-1:0]  o_point_index,
    input logic                          o_end_of_set
);

    `BNPC_ASSERT_NOW(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy, "word strobed while idle")
    `BNPC_ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, start && !busy && !i_is_final, !busy, "busy after a plain point")
    `BNPC_ASSERT_NEXT(a_final_busy, i_clk, i_rst_n, start && !busy && i_is_final, busy, "final point did not start clustering")
    `BNPC_ASSERT_NEXT(a_set_done, i_clk, i_rst_n, o_strobe && o_end_of_set, !busy, "busy held after end of set")
    `BNPC_ASSERT_NEXT(a_index_step, i_clk, i_rst_n, o_strobe && !o_end_of_set, o_strobe && (o_point_index == bnpc_pkg::INDEX_W'($past(o_point_index) + 1'b1)), "label words not consecutive")

endmodule

bind box_neighbourhood_point_clustering_unit bnpc_checker u_bnpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_is_final    (i_is_final),
    .o_strobe      (o_strobe),
    .o_point_index (o_point_index),
    .o_end_of_set  (o_end_of_set)
);
